[hdl/spms_pkg.sv]
// Shared definitions for the shared-pool multi-stack: field widths, default sizes,
// operation codes, controller state and command types.
// No dependencies.
package spms_pkg;

	// Default sizes, used by the top-level parameters.
	localparam int DEF_POOL_DEPTH = 64;
	localparam int DEF_NUM_STACKS = 8;

	// Fixed payload widths.
	localparam int VALUE_W = 32;
	localparam int SID_W   = 3;

	// Operation codes carried in the func field.
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Value returned by a pop that finds no entry.
	localparam logic [VALUE_W-1:0] POP_FAIL_VALUE = '1;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture an item and start the pool read
		logic commit;  // update the pointers and memories, load the result
	} ctl_cmd_t;

endpackage

[hdl/spms_ctrl.sv]
// Controller for the shared-pool multi-stack: two-state sequencer and the
// result-valid flag. Depends on spms_pkg for the state and command types.
module spms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output spms_pkg::ctl_cmd_t cmd
);
	import spms_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_next;
	logic       out_valid_q;
	logic       can_commit;

	// The result register may be reloaded when it is empty or being drained.
	assign can_commit = !out_valid_q || out_ready;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				if (can_commit) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.commit = can_commit;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// A result is only loaded when the result register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	// Each captured item is followed by its commit state.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_EXEC))
		else $error("captured item did not move to execution");

	// An item is never captured while another is executing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !cmd.load)
		else $error("item captured during execution");

endmodule

[hdl/spms_dp.sv]
// Datapath for the shared-pool multi-stack: stack tops, free-list head, fill count,
// the value and link memories and the result register. Depends on spms_pkg.
module spms_dp #(
	parameter int POOL_DEPTH = spms_pkg::DEF_POOL_DEPTH,
	parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spms_pkg::ctl_cmd_t           cmd,
	input  logic                         in_func,
	input  logic [spms_pkg::SID_W-1:0]   in_stack_id,
	input  logic [spms_pkg::VALUE_W-1:0] in_push_value,
	output logic                         out_ok,
	output logic [spms_pkg::VALUE_W-1:0] out_pop_value
);
	import spms_pkg::*;

	// Pointers hold POOL_DEPTH as null; entry indexes cover the pool only.
	localparam int PTR_W = $clog2(POOL_DEPTH + 1);
	localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	// Only stacks that a stack_id can name need a top register.
	localparam int TOPS  = (NUM_STACKS < (1 << SID_W)) ? NUM_STACKS : (1 << SID_W);
	localparam int TOP_W = (TOPS > 1) ? $clog2(TOPS) : 1;
	localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(POOL_DEPTH);

	// Pointer state.
	logic [PTR_W-1:0] tops_q [TOPS];
	logic [PTR_W-1:0] free_head_q;
	logic [PTR_W-1:0] hwm_q;  // entries below this have had their link written

	// Pool memories.
	logic [VALUE_W-1:0] value_mem [POOL_DEPTH];
	logic [PTR_W-1:0]   link_mem  [POOL_DEPTH];
	logic [VALUE_W-1:0] value_rd_q;
	logic [PTR_W-1:0]   link_rd_q;

	// Captured item.
	logic               func_q;
	logic [TOP_W-1:0]   tidx_q;
	logic [IDX_W-1:0]   slot_q;
	logic [VALUE_W-1:0] val_q;
	logic               hit_q;

	// Result register.
	logic               ok_q;
	logic [VALUE_W-1:0] result_q;

	// Capture-side decode.
	logic               sid_in_range;
	logic [TOP_W-1:0]   tidx;
	logic [PTR_W-1:0]   sel_ptr;
	logic               hit;

	// Commit-side values.
	logic [PTR_W-1:0]   slot_ext;
	logic               slot_fresh;
	logic [PTR_W-1:0]   link_eff;
	logic               do_push;
	logic               do_pop;

	// Decode the stack number and pick the entry the operation works on.
	assign sid_in_range = ({1'b0, in_stack_id} < (SID_W + 1)'(TOPS));
	assign tidx         = sid_in_range ? in_stack_id[TOP_W-1:0] : '0;
	assign sel_ptr      = (in_func == FUNC_POP) ? tops_q[tidx] : free_head_q;
	assign hit          = sid_in_range && (sel_ptr < PTR_NULL);

	// An entry at or above the fill count has never had its link written; its link is taken as the next entry.
	assign slot_ext   = PTR_W'(slot_q);
	assign slot_fresh = (slot_ext >= hwm_q);
	assign link_eff   = slot_fresh ? (slot_ext + PTR_W'(1)) : link_rd_q;
	assign do_push    = cmd.commit && hit_q && (func_q == FUNC_PUSH);
	assign do_pop     = cmd.commit && hit_q && (func_q == FUNC_POP);

	// Capture the item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			tidx_q <= tidx;
			slot_q <= sel_ptr[IDX_W-1:0];
			val_q  <= in_push_value;
			hit_q  <= hit;
		end
	end

	// Value memory: read on capture, written by a push.
	always_ff @(posedge clk) begin
		if (cmd.load && hit) value_rd_q <= value_mem[sel_ptr[IDX_W-1:0]];
		if (do_push) value_mem[slot_q] <= val_q;
	end

	// Link memory: read on capture, written by every successful operation.
	always_ff @(posedge clk) begin
		if (cmd.load && hit) link_rd_q <= link_mem[sel_ptr[IDX_W-1:0]];
		if (do_push) link_mem[slot_q] <= tops_q[tidx_q];
		else if (do_pop) link_mem[slot_q] <= free_head_q;
	end

	// Stack tops, free-list head and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOPS; i++) tops_q[i] <= PTR_NULL;
			free_head_q <= '0;
			hwm_q       <= '0;
		end else if (do_push) begin
			tops_q[tidx_q] <= slot_ext;
			free_head_q    <= link_eff;
			if (slot_fresh) hwm_q <= hwm_q + PTR_W'(1);
		end else if (do_pop) begin
			tops_q[tidx_q] <= link_eff;
			free_head_q    <= slot_ext;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			ok_q <= hit_q;
			if (func_q == FUNC_POP) result_q <= hit_q ? value_rd_q : POP_FAIL_VALUE;
			else result_q <= '0;
		end
	end

	assign out_ok        = ok_q;
	assign out_pop_value = result_q;

	// The free list only runs dry once every entry has been handed out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == PTR_NULL) |-> (hwm_q == PTR_NULL))
		else $error("free list empty while fresh entries remain");

	// The fill count moves up by at most one entry per item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hwm_q == $past(hwm_q)) || (hwm_q == $past(hwm_q) + PTR_W'(1)))
		else $error("fill count jumped");

	// A successful push makes its slot the new top of its stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (tops_q[$past(tidx_q)] == $past(slot_ext)))
		else $error("pushed entry is not the stack top");

	// The top of stack 0 always points at a written entry or is null.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tops_q[0] == PTR_NULL) || (tops_q[0] < hwm_q))
		else $error("stack top points at an unwritten entry");

endmodule

[hdl/shared_pool_multi_stack.sv]
// Shared-pool multi-stack top level: streaming ports, controller and datapath.
// Depends on spms_pkg, spms_ctrl and spms_dp.
//
// NUM_STACKS LIFO stacks share one pool of POOL_DEPTH entries kept on a free list.
// Each input item pushes a value onto, or pops one from, the stack named by
// stack_id and gives exactly one result item. Each item passes through two steps: in the
// accept step the top pointer or free-list head selects the pool entry and the
// synchronous read of the value and link memories is issued; in the commit step
// the pointers and memories are updated and the result register is loaded. The
// block takes no new item until the last one has committed; a held result stalls
// the commit step. No clearing pass follows reset: a fill count tells which pool
// entries still carry their reset link, so the block accepts items right away.
module shared_pool_multi_stack #(
	parameter int POOL_DEPTH = spms_pkg::DEF_POOL_DEPTH,
	parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] push_value
	input  logic [3:0]  s_axis_tuser,  // [0] func, [3:1] stack_id
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] pop_value
	output logic [0:0]  m_axis_tuser   // [0] ok
);
	import spms_pkg::*;

	ctl_cmd_t cmd;
	logic     ok;

	// Sequencer and result handshake.
	spms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Pointer state, pool memories and result register.
	spms_dp #(
		.POOL_DEPTH (POOL_DEPTH),
		.NUM_STACKS (NUM_STACKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_func       (s_axis_tuser[0]),
		.in_stack_id   (s_axis_tuser[SID_W:1]),
		.in_push_value (s_axis_tdata[VALUE_W-1:0]),
		.out_ok        (ok),
		.out_pop_value (m_axis_tdata[VALUE_W-1:0])
	);

	assign m_axis_tuser[0] = ok;

endmodule

[bench/spms_checker.sv]
// Checker for the shared-pool multi-stack: keeps its own copy of the pool, links,
// stack tops and free list, predicts each result item and compares it on arrival.
// Depends on spms_pkg.
module spms_checker #(
	parameter int POOL_DEPTH = spms_pkg::DEF_POOL_DEPTH,
	parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [spms_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] push_value
	input  logic [spms_pkg::SID_W:0]     s_axis_tuser,  // [0] func, [3:1] stack_id
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [spms_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] pop_value
	input  logic [0:0]                   m_axis_tuser,  // [0] ok
	output int                           pending,
	output int                           errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import spms_pkg::*;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
	} stack_result_t;

	// Shadow of the block's state; a pointer not below POOL_DEPTH is null.
	logic [VALUE_W-1:0] entry_value [POOL_DEPTH];
	int                 entry_link [POOL_DEPTH];
	int                 stack_top [NUM_STACKS];
	int                 free_head;

	stack_result_t      expected_results [$];
	stack_result_t      want;
	int                 new_errors;

	// Applies one push or pop to the shadow state and returns the result it gives.
	function automatic stack_result_t apply_stack_op(input logic func,
			input logic [SID_W-1:0] sid, input logic [VALUE_W-1:0] value);
		stack_result_t res;
		int            slot;
		res.ok = 1'b0;
		res.value = (func == FUNC_PUSH) ? '0 : POP_FAIL_VALUE;
		if (int'(sid) < NUM_STACKS) begin
			if (func == FUNC_PUSH) begin
				if (free_head < POOL_DEPTH) begin
					slot = free_head;
					free_head = entry_link[slot];
					entry_value[slot] = value;
					entry_link[slot] = stack_top[sid];
					stack_top[sid] = slot;
					res.ok = 1'b1;
				end
			end else if (stack_top[sid] < POOL_DEPTH) begin
				slot = stack_top[sid];
				stack_top[sid] = entry_link[slot];
				entry_link[slot] = free_head;
				free_head = slot;
				res.value = entry_value[slot];
				res.ok = 1'b1;
			end
		end
		return res;
	endfunction

	// Compare the arriving result first, then predict the item taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_DEPTH; i++) begin
				entry_value[i] = '0;
				entry_link[i] = i + 1;
			end
			for (int i = 0; i < NUM_STACKS; i++)
				stack_top[i] = POOL_DEPTH;
			free_head = 0;
			expected_results.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			new_errors = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result item with nothing expected: ok=%0d pop_value=%0d",
						m_axis_tuser[0], $signed(m_axis_tdata));
					new_errors++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tuser[0] !== want.ok) begin
						$error("ok: expected %0d, actual %0d", want.ok, m_axis_tuser[0]);
						new_errors++;
					end
					if (m_axis_tdata !== want.value) begin
						$error("pop_value: expected %0d, actual %0d",
							$signed(want.value), $signed(m_axis_tdata));
						new_errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_stack_op(s_axis_tuser[0],
					s_axis_tuser[SID_W:1], s_axis_tdata));
			pending <= expected_results.size();
			errors <= errors + new_errors;
		end
	end

endmodule

[bench/shared_pool_multi_stack_tb.sv]
// Top of the shared-pool multi-stack bench: clock, reset, push/pop stimulus and
// result-side back-pressure, watchdog and verdict.
// Depends on spms_pkg, shared_pool_multi_stack and spms_checker.
module shared_pool_multi_stack_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spms_pkg::*;

	localparam int POOL_DEPTH = DEF_POOL_DEPTH;
	localparam int NUM_STACKS = DEF_NUM_STACKS;
	localparam int ITEM_TARGET = 1850;
	localparam int MAX_WAIT = 17;
	localparam int STALL_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [VALUE_W-1:0] s_axis_tdata = '0;   // [31:0] push_value
	logic [SID_W:0]     s_axis_tuser = '0;   // [0] func, [3:1] stack_id
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [VALUE_W-1:0] m_axis_tdata;        // [31:0] pop_value
	logic [0:0]         m_axis_tuser;        // [0] ok

	int                 pending;
	int                 errors;
	int                 quiet_cycles = 0;
	int unsigned        rx_hold = 0;
	int unsigned        rx_draw;
	logic               rx_steady = 1'b0;
	logic               tx_steady = 1'b0;

	shared_pool_multi_stack #(
		.POOL_DEPTH(POOL_DEPTH),
		.NUM_STACKS(NUM_STACKS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	spms_checker #(
		.POOL_DEPTH(POOL_DEPTH),
		.NUM_STACKS(NUM_STACKS)
	) stack_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.pending      (pending),
		.errors       (errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: after each taken result, hold tready low for a random count.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			rx_draw = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
			rx_hold <= rx_draw;
			m_axis_tready <= (rx_draw == 0);
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= (rx_hold == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog: too long without any item moving on either side ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("shared_pool_multi_stack_tb: errors");
			$finish;
		end
	end

	// Offers one item after a random gap and returns at the edge that takes it.
	task automatic send_item(input logic func, input logic [SID_W-1:0] sid,
			input logic [VALUE_W-1:0] value);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= {sid, func};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stops sending until every predicted result has been taken.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int               sent;
		int               phase;
		int               phase_len;
		int               push_pct;
		logic             focus;
		logic [SID_W-1:0] focus_sid;
		logic             op;
		logic [SID_W-1:0] sid;
		logic [VALUE_W-1:0] value;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops on empty stacks, extreme values, a stored -1, LIFO order.
		send_item(FUNC_POP, 3'd0, 32'h1234_5678);
		send_item(FUNC_POP, 3'd7, '0);
		send_item(FUNC_PUSH, 3'd0, 32'h7FFF_FFFF);
		send_item(FUNC_PUSH, 3'd0, 32'h8000_0000);
		send_item(FUNC_PUSH, 3'd7, 32'hFFFF_FFFF);
		send_item(FUNC_PUSH, 3'd3, 32'h0000_0000);
		send_item(FUNC_PUSH, 3'd5, 32'h5555_5555);
		send_item(FUNC_PUSH, 3'd2, 32'hAAAA_AAAA);
		send_item(FUNC_POP, 3'd7, 32'hFFFF_FFFF);
		send_item(FUNC_POP, 3'd7, '0);
		send_item(FUNC_POP, 3'd0, '0);
		send_item(FUNC_POP, 3'd0, '0);
		send_item(FUNC_POP, 3'd0, '0);
		send_item(FUNC_POP, 3'd3, '0);
		send_item(FUNC_POP, 3'd5, '0);
		send_item(FUNC_POP, 3'd2, '0);
		send_item(FUNC_PUSH, 3'd1, 32'h0000_0001);
		send_item(FUNC_PUSH, 3'd4, 32'hFFFF_FFFE);
		send_item(FUNC_PUSH, 3'd6, 32'h0F0F_F0F0);
		send_item(FUNC_POP, 3'd6, '0);
		send_item(FUNC_POP, 3'd4, '0);
		send_item(FUNC_POP, 3'd1, '0);
		sent = 22;
		drain_results();

		// Random phases: push-heavy runs fill the pool past full, pop-heavy runs
		// empty the stacks; some phases work one stack only.
		phase = 0;
		while (sent < ITEM_TARGET) begin
			if (phase == 0) begin
				phase_len = 110;
				push_pct = 95;
			end else begin
				phase_len = $urandom_range(16, 120);
				case ($urandom_range(0, 2))
					0: push_pct = 90;
					1: push_pct = 50;
					default: push_pct = 12;
				endcase
			end
			focus = ($urandom_range(0, 3) == 0);
			focus_sid = SID_W'($urandom_range(0, NUM_STACKS - 1));
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady <= ($urandom_range(0, 4) == 0);
			repeat (phase_len) begin
				op = ($urandom_range(1, 100) <= push_pct) ? FUNC_PUSH : FUNC_POP;
				sid = focus ? focus_sid : SID_W'($urandom_range(0, NUM_STACKS - 1));
				case ($urandom_range(0, 11))
					0: value = '0;
					1: value = '1;
					2: value = 32'h8000_0000;
					3: value = 32'h7FFF_FFFF;
					default: value = $urandom();
				endcase
				send_item(op, sid, value);
				sent++;
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
			phase++;
		end

		// Let the last results arrive, then watch for stray output before the verdict.
		tx_steady = 1'b0;
		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("shared_pool_multi_stack_tb: clean");
		else
			$display("shared_pool_multi_stack_tb: errors");
		$finish;
	end

endmodule

[sim.f]
hdl/spms_pkg.sv
hdl/spms_ctrl.sv
hdl/spms_dp.sv
hdl/shared_pool_multi_stack.sv
bench/spms_checker.sv
bench/shared_pool_multi_stack_tb.sv
